// ===== hw/rtl/gcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcc_pkg: shared types and constants of the greedy coin change core
// Widths, coin slot count, reset denominations and the job record that runs
// from the front end through the queue to the divider back end.
// ----------------------------------------------------------------------------
package gcc_pkg;

   localparam int DATA_W     = 16;
   localparam int NUM_COINS  = 5;   // 1 .. 8
   localparam int COIN_IDX_W = (NUM_COINS > 1) ? $clog2(NUM_COINS) : 1;
   localparam int COIN_CNT_W = $clog2(NUM_COINS + 1);

   // divider retires this many quotient bits per cycle
   localparam int DIV_BITS   = 4;
   localparam int DIV_STEPS  = DATA_W / DIV_BITS;
   localparam int STEP_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DATA_W-1:0] COIN_RESET [8] = '{
      16'd50, 16'd10, 16'd5, 16'd2, 16'd1, 16'd0, 16'd0, 16'd0
   };

   typedef logic [DATA_W-1:0] word_type;

   // one amount with its denominations already in payout order
   typedef struct packed {
      word_type                        amount;
      logic [NUM_COINS-1:0][DATA_W-1:0] value;   // value[0] paid first
      logic [COIN_CNT_W-1:0]           num;     // nonzero denominations
   } job_type;

endpackage

// ===== hw/rtl/greedy_coin_change_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_coin_change_core: greedy change maker over five coin registers
// Pays an amount largest denomination first, one result per nonzero
// denomination (count taken, amount left), last marked on the final one.
// ----------------------------------------------------------------------------
//
//  channel   ports                                         transfer when
//  --------  --------------------------------------------  ------------------
//  request   start, busy, req_amount                       start && !busy
//  result    rsp_valid, rsp_coin_value, rsp_coin_count,    rsp_valid (1 cycle)
//            rsp_remaining, rsp_last
//  csr       csr_wr_en, csr_index, csr_wr_data             csr_wr_en
//
//  Each nonzero denomination, up to 5 of them, is one divide in the shared
//  restoring divider, 4 quotient bits a cycle. An amount loads through the
//  idle state when the back end was idle, else it chains on from the last.
//  With every register zero it gives its single result from the idle state.
//  From idle, a result passes the queue, idle load, divide steps, result register.
//  Reset is synchronous, active high; coin registers return to 50/10/5/2/1.
//  busy is high in reset and when the two-entry job queue is full; results
//  cannot be held off, so the back end never stalls.
//
module greedy_coin_change_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [gcc_pkg::DATA_W-1:0]    req_amount,
   output logic                          rsp_valid,
   output logic [gcc_pkg::DATA_W-1:0]    rsp_coin_value,
   output logic [gcc_pkg::DATA_W-1:0]    rsp_coin_count,
   output logic [gcc_pkg::DATA_W-1:0]    rsp_remaining,
   output logic                          rsp_last,
   input  logic                          csr_wr_en,
   input  logic [gcc_pkg::COIN_IDX_W-1:0] csr_index,
   input  logic [gcc_pkg::DATA_W-1:0]    csr_wr_data
);
   import gcc_pkg::*;

   // front end -> queue
   logic    push_valid;
   job_type push_job;
   logic    queue_full;

   // queue -> back end
   logic    head_valid;
   job_type head_job;
   logic    pop;

   // Front end: coin registers and ordering. The order is taken at request
   // time, so a register write lands on the next amount accepted.
   gcc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_amount  (req_amount),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_job    (push_job)
   );

   // Two jobs of slack between acceptance and payout
   gcc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   // Back end: one divide per denomination, registered results
   gcc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_coin_value (rsp_coin_value),
      .rsp_coin_count (rsp_coin_count),
      .rsp_remaining  (rsp_remaining),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== hw/rtl/gcc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcc_front: request acceptance and denomination ordering
// Holds the coin registers, ranks the denominations largest first (ties in
// register order, zero slots last) and pushes each accepted amount as a job.
// ----------------------------------------------------------------------------
module gcc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [gcc_pkg::DATA_W-1:0]    req_amount,
   input  logic                          csr_wr_en,
   input  logic [gcc_pkg::COIN_IDX_W-1:0] csr_index,
   input  logic [gcc_pkg::DATA_W-1:0]    csr_wr_data,
   input  logic                          queue_full,
   output logic                          push_valid,
   output gcc_pkg::job_type              push_job
);
   import gcc_pkg::*;

   logic [DATA_W-1:0]     coin_ff [NUM_COINS];
   logic [COIN_IDX_W-1:0] rank [NUM_COINS];
   logic [COIN_CNT_W-1:0] num_nonzero;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COINS; i++) begin
            coin_ff[i] <= COIN_RESET[i];
         end
      end else if (csr_wr_en &&
                   ({1'b0, csr_index} < (COIN_IDX_W + 1)'(NUM_COINS))) begin
         coin_ff[csr_index] <= csr_wr_data;
      end
   end

   // rank = number of slots paid before this one
   always_comb begin
      for (int i = 0; i < NUM_COINS; i++) begin
         rank[i] = '0;
         for (int j = 0; j < NUM_COINS; j++) begin
            if (j != i) begin
               if ((coin_ff[j] > coin_ff[i]) || ((coin_ff[j] == coin_ff[i]) && (j < i))) begin
                  rank[i] = rank[i] + COIN_IDX_W'(1);
               end
            end
         end
      end
   end

   always_comb begin
      num_nonzero = '0;
      for (int i = 0; i < NUM_COINS; i++) begin
         if (coin_ff[i] != '0) begin
            num_nonzero = num_nonzero + COIN_CNT_W'(1);
         end
      end
   end

   // ranks form a permutation, so an OR of the matches selects one slot
   always_comb begin
      push_job.amount = req_amount;
      push_job.num    = num_nonzero;
      for (int p = 0; p < NUM_COINS; p++) begin
         push_job.value[p] = '0;
         for (int i = 0; i < NUM_COINS; i++) begin
            if (rank[i] == COIN_IDX_W'(p)) begin
               push_job.value[p] = push_job.value[p] | coin_ff[i];
            end
         end
      end
   end

   // no transfer is taken while in reset
   assign busy       = queue_full || reset;
   assign push_valid = start && !busy;

endmodule

// ===== hw/rtl/gcc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcc_queue: two-entry job queue
// Decouples request acceptance from the divider back end.
// ----------------------------------------------------------------------------
module gcc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  gcc_pkg::job_type push_job,
   output logic             full,
   output logic             head_valid,
   output gcc_pkg::job_type head_job,
   input  logic             pop
);
   import gcc_pkg::*;

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   fill_ff, fill_in;
   logic                do_push, do_pop;

   assign full       = (fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== hw/rtl/gcc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcc_back: divider back end
// Pays out one job: for each denomination in turn a restoring divide of the
// unpaid amount, DIV_BITS quotient bits a cycle, one registered result each.
// ----------------------------------------------------------------------------
module gcc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  gcc_pkg::job_type           head_job,
   output logic                       pop,
   output logic                       rsp_valid,
   output logic [gcc_pkg::DATA_W-1:0] rsp_coin_value,
   output logic [gcc_pkg::DATA_W-1:0] rsp_coin_count,
   output logic [gcc_pkg::DATA_W-1:0] rsp_remaining,
   output logic                       rsp_last
);
   import gcc_pkg::*;

   typedef enum logic {ST_IDLE, ST_DIV} state_type;

   state_type             state_ff, state_in;
   job_type               job_ff, job_in;
   logic [COIN_IDX_W-1:0] pos_ff, pos_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DATA_W-1:0]     quo_ff, quo_in;    // dividend shifts out, quotient in
   logic [DATA_W-1:0]     rem_ff, rem_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]     rsp_value_ff, rsp_value_in;
   logic [DATA_W-1:0]     rsp_count_ff, rsp_count_in;
   logic [DATA_W-1:0]     rsp_rem_ff, rsp_rem_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [DATA_W-1:0]     divisor;
   logic [DATA_W-1:0]     quo_nx, rem_nx;
   logic                  step_last, coin_last;

   assign divisor   = job_ff.value[pos_ff];
   assign step_last = (step_ff == STEP_W'(DIV_STEPS - 1));
   assign coin_last = ((COIN_CNT_W'(pos_ff) + COIN_CNT_W'(1)) == job_ff.num);

   // DIV_BITS restoring steps
   always_comb begin
      logic [DATA_W:0]   trial;
      logic [DATA_W-1:0] q, r;
      q = quo_ff;
      r = rem_ff;
      for (int k = 0; k < DIV_BITS; k++) begin
         trial = {r, q[DATA_W-1]};
         q     = {q[DATA_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            r    = DATA_W'(trial - {1'b0, divisor});
            q[0] = 1'b1;
         end else begin
            r = trial[DATA_W-1:0];
         end
      end
      quo_nx = q;
      rem_nx = r;
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      pos_in       = pos_ff;
      step_in      = step_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;
      rsp_rem_in   = rsp_rem_ff;
      rsp_last_in  = rsp_last_ff;
      pop          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop    = 1'b1;
               job_in = head_job;
               pos_in = '0;
               step_in = '0;
               quo_in = head_job.amount;
               rem_in = '0;
               if (head_job.num == '0) begin
                  // no denomination set: the whole amount stays unpaid
                  rsp_valid_in = 1'b1;
                  rsp_value_in = '0;
                  rsp_count_in = '0;
                  rsp_rem_in   = head_job.amount;
                  rsp_last_in  = 1'b1;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            quo_in  = quo_nx;
            rem_in  = rem_nx;
            step_in = step_ff + STEP_W'(1);
            if (step_last) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = divisor;
               rsp_count_in = quo_nx;
               rsp_rem_in   = rem_nx;
               rsp_last_in  = coin_last;
               step_in      = '0;
               if (!coin_last) begin
                  pos_in = pos_ff + COIN_IDX_W'(1);
                  quo_in = rem_nx;
                  rem_in = '0;
               end else if (head_valid && (head_job.num != '0)) begin
                  // chain straight into the next job
                  pop    = 1'b1;
                  job_in = head_job;
                  pos_in = '0;
                  quo_in = head_job.amount;
                  rem_in = '0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff       <= job_in;
      pos_ff       <= pos_in;
      step_ff      <= step_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
      rsp_rem_ff   <= rsp_rem_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_coin_value = rsp_value_ff;
   assign rsp_coin_count = rsp_count_ff;
   assign rsp_remaining  = rsp_rem_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== tb/tb_greedy_coin_change_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_greedy_coin_change_core: self-checking bench for the greedy change maker
// Drives amounts through the start/busy port under several coin settings,
// predicts every per-denomination line and checks each strobed result.
// ----------------------------------------------------------------------------
module tb_greedy_coin_change_core;
   import gcc_pkg::*;

   localparam int CLK_HALF        = 4;     // 8 ns period
   localparam int RESET_CYCLES    = 9;
   localparam int CONFIG_SETTLE   = 8;     // quiet cycles before a coin write
   localparam int END_SETTLE      = 64;    // margin for the worst amount, two queued
   localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no transfer at all
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_AMOUNTS   = 50;

   // coin register map, index = position in the register list
   typedef enum logic [COIN_IDX_W-1:0] {
      COIN_A, COIN_B, COIN_C, COIN_D, COIN_E
   } coin_reg_type;

   // one expected payout line
   typedef struct {
      word_type value;
      word_type count;
      word_type remaining;
      logic     last;
   } coin_line_type;

   // --------------------------------------------------------------------------
   // Payout predictor and line checker. Keeps its own copy of the coin
   // registers, expands each accepted amount into its payout lines and
   // compares the strobed results against them in order.
   // --------------------------------------------------------------------------
   class payout_checker;
      word_type      coin [NUM_COINS];
      coin_line_type payout_q [$];
      int            mismatch_count;

      function new();
         for (int i = 0; i < NUM_COINS; i++) coin[i] = COIN_RESET[i];
         mismatch_count = 0;
      endfunction

      // spare indexes above the last slot are ignored by the block
      function void set_coin(int index, word_type value);
         if (index < NUM_COINS) coin[index] = value;
      endfunction

      function int pending();
         return payout_q.size();
      endfunction

      // Largest untaken nonzero coin first; strict compare keeps the lower
      // index on a tie, so a repeated value pays nothing on its later copy.
      function void note_amount(word_type amount);
         logic [NUM_COINS-1:0] taken;
         coin_line_type        lines [NUM_COINS];
         coin_line_type        none_line;
         word_type             left;
         word_type             best;
         int                   pick;
         int                   num_lines;
         for (int i = 0; i < NUM_COINS; i++) taken[i] = (coin[i] == '0);
         left      = amount;
         num_lines = 0;
         for (int r = 0; r < NUM_COINS; r++) begin
            pick = -1;
            best = '0;
            for (int i = 0; i < NUM_COINS; i++) begin
               if (!taken[i] && coin[i] > best) begin
                  best = coin[i];
                  pick = i;
               end
            end
            if (pick < 0) break;
            taken[pick]                = 1'b1;
            lines[num_lines].value     = best;
            lines[num_lines].count     = left / best;
            left                       = left % best;
            lines[num_lines].remaining = left;
            lines[num_lines].last      = 1'b0;
            num_lines++;
         end
         if (num_lines == 0) begin
            // no coins configured: one line, nothing paid
            none_line.value     = '0;
            none_line.count     = '0;
            none_line.remaining = amount;
            none_line.last      = 1'b1;
            payout_q.push_back(none_line);
         end else begin
            lines[num_lines-1].last = 1'b1;
            for (int k = 0; k < num_lines; k++) payout_q.push_back(lines[k]);
         end
      endfunction

      function void report(string field, int unsigned want, int unsigned got);
         mismatch_count++;
         $error("%s: expected %0d, actual %0d", field, want, got);
      endfunction

      function void check_line(word_type value, word_type count,
                               word_type remaining, logic last);
         coin_line_type want;
         if (payout_q.size() == 0) begin
            mismatch_count++;
            $error("unexpected result: coin_value %0d coin_count %0d", value, count);
            return;
         end
         want = payout_q.pop_front();
         if (value !== want.value)         report("coin_value", want.value, value);
         if (count !== want.count)         report("coin_count", want.count, count);
         if (remaining !== want.remaining) report("remaining", want.remaining, remaining);
         if (last !== want.last)           report("last", want.last, last);
      endfunction
   endclass

   // --------------------------------------------------------------------------
   // DUT signals, all inputs known from time zero
   // --------------------------------------------------------------------------
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  start       = 1'b0;
   logic                  busy;
   word_type              req_amount  = '0;
   logic                  rsp_valid;
   word_type              rsp_coin_value;
   word_type              rsp_coin_count;
   word_type              rsp_remaining;
   logic                  rsp_last;
   logic                  csr_wr_en   = 1'b0;
   logic [COIN_IDX_W-1:0] csr_index   = '0;
   word_type              csr_wr_data = '0;

   payout_checker payouts = new();
   int            quiet_cycles = 0;

   greedy_coin_change_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_amount     (req_amount),
      .rsp_valid      (rsp_valid),
      .rsp_coin_value (rsp_coin_value),
      .rsp_coin_count (rsp_coin_count),
      .rsp_remaining  (rsp_remaining),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // --------------------------------------------------------------------------
   // Monitor: everything is sampled on the rising edge, so the values seen
   // are the ones that stood through the cycle that edge ends. A request
   // transfer is start && !busy; a result is any strobed cycle, since the
   // result side has no back-pressure. The watchdog counts edges at which
   // nothing at all transferred.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) payouts.note_amount(req_amount);
         if (rsp_valid)
            payouts.check_line(rsp_coin_value, rsp_coin_count, rsp_remaining, rsp_last);
         if ((start && !busy) || rsp_valid || csr_wr_en) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Drivers. All drive updates are nonblocking, just after a rising edge.
   // --------------------------------------------------------------------------

   // one register write; the enable drops for a cycle between writes so it
   // never gets two updates in one step
   task automatic write_coin(input logic [COIN_IDX_W-1:0] index, input word_type value);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      @(posedge clock);
      payouts.set_coin(index, value);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_coins(input word_type a, input word_type b, input word_type c,
                             input word_type d, input word_type e);
      write_coin(COIN_A, a);
      write_coin(COIN_B, b);
      write_coin(COIN_C, c);
      write_coin(COIN_D, d);
      write_coin(COIN_E, e);
   endtask

   // Present one amount and hold it until it transfers. With idle_pct > 0
   // the sender may drop start first, idle while each draw is under idle_pct;
   // start is left high after the transfer so back-to-back amounts stream.
   task automatic send_amount(input word_type amount, input int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start      <= 1'b0;
         req_amount <= word_type'($urandom);   // junk while idle
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start      <= 1'b1;
      req_amount <= amount;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Stop sending and wait for every predicted line to come back. The first
   // edge makes sure the monitor has logged the final request transfer.
   task automatic drain(input int settle);
      start <= 1'b0;
      @(posedge clock);
      while (payouts.pending() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   function automatic word_type pick_amount();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3:    return word_type'($urandom_range(255));
         4:       return word_type'(1) << $urandom_range(DATA_W - 1);
         default: return word_type'($urandom);
      endcase
   endfunction

   function automatic word_type pick_coin();
      case ($urandom_range(9))
         0, 1:    return '0;
         2:       return word_type'(1);
         3:       return '1;
         4, 5:    return word_type'($urandom_range(20, 1));
         6, 7:    return word_type'($urandom_range(1000, 1));
         default: return word_type'($urandom);
      endcase
   endfunction

   // --------------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------------
   initial begin
      word_type coins [NUM_COINS];
      int       idle_levels [3];
      int       idle_pct;

      idle_levels = '{0, 46, 12};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset denominations 50/10/5/2/1: nothing to pay, the top of the range,
      // one each of 50, 10, 5 and 2, and a single smallest coin
      send_amount('0, 0);
      send_amount('1, 0);
      send_amount(16'd67, 0);
      send_amount(16'd1, 0);
      drain(CONFIG_SETTLE);

      // no coins configured at all: a single empty line carrying the amount
      load_coins('0, '0, '0, '0, '0);
      send_amount('0, 0);
      send_amount('1, 0);
      drain(CONFIG_SETTLE);

      // repeated denominations: the later copy pays nothing
      load_coins(16'd7, 16'd7, 16'd3, 16'd3, '0);
      send_amount(16'd20, 0);
      send_amount('0, 0);
      drain(CONFIG_SETTLE);

      // equal values visited in index order, with a gap slot among them
      load_coins(16'd3, 16'd9, 16'd9, '0, 16'd9);
      send_amount(16'd31, 0);
      drain(CONFIG_SETTLE);

      // extreme denominations
      load_coins('1, 16'd1, '1, 16'h8000, 16'h7fff);
      send_amount('1, 0);
      send_amount(16'hfffe, 0);
      send_amount(16'h7fff, 0);
      drain(CONFIG_SETTLE);

      // writes to the spare indexes above the last slot must leave the coins alone
      for (int k = NUM_COINS; k < (1 << COIN_IDX_W); k++)
         write_coin(COIN_IDX_W'(k), '1);
      send_amount(16'd100, 0);
      drain(CONFIG_SETTLE);

      // random phases: fresh coin set each time, sender gaps cycle through
      // none, heavy and light
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         for (int i = 0; i < NUM_COINS; i++) begin
            coins[i] = pick_coin();
            // encourage repeated values
            if (i > 0 && $urandom_range(6) == 0) coins[i] = coins[$urandom_range(i - 1)];
         end
         if ($urandom_range(7) == 0)
            for (int i = 0; i < NUM_COINS; i++) coins[i] = '0;
         load_coins(coins[0], coins[1], coins[2], coins[3], coins[4]);
         if ($urandom_range(1) == 0)
            write_coin(COIN_IDX_W'($urandom_range((1 << COIN_IDX_W) - 1, NUM_COINS)),
                       word_type'($urandom));

         idle_pct = idle_levels[p % 3];
         for (int n = 0; n < PHASE_AMOUNTS; n++) send_amount(pick_amount(), idle_pct);
         drain(CONFIG_SETTLE);
      end

      drain(END_SETTLE);
      if (payouts.mismatch_count == 0 && payouts.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
